[hdl/sound_source_track_table_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sound source track table
// Short forms for same-cycle and next-cycle implications, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SOUND_SOURCE_TRACK_TABLE_MACROS_SVH
`define SOUND_SOURCE_TRACK_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSTT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// antecedent implies consequent in the next cycle
`define SSTT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hdl/sstt_pkg.sv]
// ----------------------------------------------------------------------------
// sstt_pkg
// Types and codes shared by the sound source track table modules.
// ----------------------------------------------------------------------------
package sstt_pkg;

  typedef enum logic [2:0] {
    EV_UPDATE = 3'd0,
    EV_MERGE  = 3'd1,
    EV_ADD    = 3'd2,
    EV_DROP   = 3'd3,
    EV_REMOVE = 3'd4
  } event_kind_t;

  localparam logic [1:0] CFG_ANGLE_GATE    = 2'd0;
  localparam logic [1:0] CFG_DISTANCE_GATE = 2'd1;
  localparam logic [1:0] CFG_MAX_AGE       = 2'd2;

  localparam logic [3:0] MAX_REMOVALS = 4'd15;

  typedef struct packed {
    logic        [15:0] ident;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [8:0]  angle;
    logic        [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic done;
    logic hit;
  } dist_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_DIST,
    S_DECIDE,
    S_PUSH,
    S_FLUSH,
    S_AG_INIT,
    S_AG_RD,
    S_AG_CHK,
    S_AG_RANK,
    S_AG_NEXT,
    S_AG_END
  } state_t;

endpackage

[hdl/sound_source_track_table.sv]
// Operation: a detection walks the used entries in order, checking the distance of
// each entry inside the angle gate until a merge is found, then posts its event;
// an ID match ends the walk early. At a message's last detection the aging sort ranks
// the entries and posts each removal, paced by the single read port of the table memory.
// Throughput: one detection at a time; the input stalls until it is finished.
// Reset: table empty, gates at defaults, memory contents left undefined.
// ----------------------------------------------------------------------------
// sound_source_track_table
// Track table of sound sources kept in a two-bank synchronous memory.
// ----------------------------------------------------------------------------
module sound_source_track_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               det_valid,
  output logic               det_stall,
  input  logic [15:0]        source_id,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [8:0]  azimuth,
  input  logic [31:0]        stamp,
  input  logic               last_in_message,
  output logic               evt_valid,
  input  logic               evt_stall,
  output logic [2:0]         event_kind,
  output logic [3:0]         slot,
  output logic [15:0]        entry_id,
  output logic [3:0]         changed_mask,
  output logic               last_result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam int MD = 2 ** AW;
  localparam logic [CW-1:0] FULL_N = CW'(TABLE_DEPTH - 1);

  sstt_pkg::state_t state, state_next, ret;

  sstt_pkg::entry_t mem [MD];
  sstt_pkg::entry_t rd_data, wd;
  logic [AW-1:0]    rd_addr, wa;
  logic             we;

  logic          bank;
  logic [CW-1:0] count;
  logic [31:0]   mtime;
  logic          expect_first;
  logic [8:0]    angle_gate;
  logic [15:0]   distance_gate;
  logic [15:0]   max_age;
  logic [31:0]   g2;

  sstt_pkg::entry_t it;
  logic             it_last;
  logic [CW-1:0]    idx;
  sstt_pkg::entry_t cur;
  logic             merge_found;
  logic [IW-1:0]    merge_idx;
  sstt_pkg::entry_t merge_rec;

  sstt_pkg::event_kind_t res_kind, pend_kind, out_kind;
  logic [3:0]  res_slot, pend_slot, out_slot;
  logic [15:0] res_id, pend_id, out_id;
  logic [3:0]  res_mask, pend_mask, out_mask;
  logic        pend_valid, out_last;

  logic [CW-1:0]    rank, kept;
  logic [3:0]       nrem;
  logic             have_prev, best_valid;
  logic [31:0]      prev_age, best_age;
  logic [IW-1:0]    prev_idx, best_idx;
  sstt_pkg::entry_t best;

  logic        id_match, try_merge, out_free, push_ok, removing, out_load;
  logic        after_prev, better;
  logic [9:0]  ang_diff, ang_abs;
  logic [16:0] dx17, dy17, dz17;
  logic [15:0] dx_abs, dy_abs, dz_abs;
  logic [3:0]  mask;
  logic [31:0] ag_age;
  logic        dist_start;
  sstt_pkg::dist_res_t dres;

  sstt_dist u_dist (
    .clk   (clk),
    .rst   (rst),
    .start (dist_start),
    .dx    (dx_abs),
    .dy    (dy_abs),
    .dz    (dz_abs),
    .g2    (g2),
    .res   (dres)
  );

  // table memory, one read and one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    id_match  = (rd_data.ident == it.ident);
    ang_diff  = {rd_data.angle[8], rd_data.angle} - {it.angle[8], it.angle};
    ang_abs   = ang_diff[9] ? (~ang_diff + 10'd1) : ang_diff;
    try_merge = !merge_found && (ang_abs < {1'b0, angle_gate});
    dx17      = {rd_data.x[15], rd_data.x} - {it.x[15], it.x};
    dy17      = {rd_data.y[15], rd_data.y} - {it.y[15], it.y};
    dz17      = {rd_data.z[15], rd_data.z} - {it.z[15], it.z};
    dx_abs    = dx17[16] ? 16'(~dx17 + 17'd1) : dx17[15:0];
    dy_abs    = dy17[16] ? 16'(~dy17 + 17'd1) : dy17[15:0];
    dz_abs    = dz17[16] ? 16'(~dz17 + 17'd1) : dz17[15:0];
    mask      = {rd_data.angle != it.angle, rd_data.z != it.z,
                 rd_data.y != it.y, rd_data.x != it.x};
    out_free  = !evt_valid || !evt_stall;
    push_ok   = !pend_valid || out_free;
    out_load  = ((state == sstt_pkg::S_PUSH) && push_ok && pend_valid) ||
                ((state == sstt_pkg::S_FLUSH) && out_free);
    ag_age    = mtime - rd_data.stamp;
    after_prev = !have_prev || (ag_age > prev_age) ||
                 ((ag_age == prev_age) && (idx[IW-1:0] > prev_idx));
    better    = !best_valid || (ag_age < best_age);
    removing  = (best_age >= {16'd0, max_age});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sstt_pkg::S_IDLE:    if (det_valid) state_next = sstt_pkg::S_RD;
      sstt_pkg::S_RD:      state_next = (idx == count) ? sstt_pkg::S_DECIDE : sstt_pkg::S_CHK;
      sstt_pkg::S_CHK: begin
        if (id_match)       state_next = sstt_pkg::S_PUSH;
        else if (try_merge) state_next = sstt_pkg::S_DIST;
        else                state_next = sstt_pkg::S_RD;
      end
      sstt_pkg::S_DIST:    if (dres.done) state_next = sstt_pkg::S_RD;
      sstt_pkg::S_DECIDE:  state_next = sstt_pkg::S_PUSH;
      sstt_pkg::S_PUSH:    if (push_ok) state_next = ret;
      sstt_pkg::S_FLUSH:   if (out_free) state_next = sstt_pkg::S_IDLE;
      sstt_pkg::S_AG_INIT: begin
        state_next = (count == '0) ? sstt_pkg::S_AG_END : sstt_pkg::S_AG_RD;
      end
      sstt_pkg::S_AG_RD: begin
        state_next = (idx == count) ? sstt_pkg::S_AG_RANK : sstt_pkg::S_AG_CHK;
      end
      sstt_pkg::S_AG_CHK:  state_next = sstt_pkg::S_AG_RD;
      sstt_pkg::S_AG_RANK: begin
        state_next = (removing && nrem < sstt_pkg::MAX_REMOVALS) ?
                     sstt_pkg::S_PUSH : sstt_pkg::S_AG_NEXT;
      end
      sstt_pkg::S_AG_NEXT: begin
        state_next = (rank + 1'b1 == count) ? sstt_pkg::S_AG_END : sstt_pkg::S_AG_RD;
      end
      sstt_pkg::S_AG_END:  state_next = sstt_pkg::S_FLUSH;
      default:             state_next = sstt_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    det_stall  = (state != sstt_pkg::S_IDLE);
    rd_addr    = {bank, idx[IW-1:0]};
    we         = 1'b0;
    wa         = {bank, idx[IW-1:0]};
    wd         = it;
    dist_start = 1'b0;
    unique case (state)
      sstt_pkg::S_CHK: begin
        if (id_match) begin
          we = 1'b1;
        end else begin
          dist_start = try_merge;
        end
      end
      sstt_pkg::S_DECIDE: begin
        if (merge_found) begin
          we       = 1'b1;
          wa       = {bank, merge_idx};
          wd       = merge_rec;
          wd.stamp = it.stamp;
        end else if (count < FULL_N) begin
          we = 1'b1;
          wa = {bank, count[IW-1:0]};
        end
      end
      sstt_pkg::S_AG_RANK: begin
        // survivors go to the other bank, youngest first
        we = !removing;
        wa = {~bank, kept[IW-1:0]};
        wd = best;
      end
      default: ;
    endcase
  end

  assign cfg_ready    = 1'b1;
  assign event_kind   = out_kind;
  assign slot         = out_slot;
  assign entry_id     = out_id;
  assign changed_mask = out_mask;
  assign last_result  = out_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sstt_pkg::S_IDLE;
      bank          <= 1'b0;
      count         <= '0;
      mtime         <= 32'd0;
      expect_first  <= 1'b1;
      angle_gate    <= 9'd10;
      distance_gate <= 16'd50;
      max_age       <= 16'd100;
      pend_valid    <= 1'b0;
      evt_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          sstt_pkg::CFG_ANGLE_GATE:    angle_gate    <= cfg_data[8:0];
          sstt_pkg::CFG_DISTANCE_GATE: distance_gate <= cfg_data;
          sstt_pkg::CFG_MAX_AGE:       max_age       <= cfg_data;
          default: ;
        endcase
      end
      if (out_load) begin
        evt_valid <= 1'b1;
      end else if (evt_valid && !evt_stall) begin
        evt_valid <= 1'b0;
      end
      unique case (state)
        sstt_pkg::S_IDLE: begin
          if (det_valid && expect_first) begin
            mtime        <= stamp;
            expect_first <= 1'b0;
          end
        end
        sstt_pkg::S_DECIDE: begin
          if (!merge_found && count < FULL_N) begin
            count <= count + 1'b1;
          end
        end
        sstt_pkg::S_PUSH: begin
          if (push_ok) begin
            pend_valid <= 1'b1;
          end
        end
        sstt_pkg::S_FLUSH: begin
          if (out_free) begin
            pend_valid <= 1'b0;
          end
        end
        sstt_pkg::S_AG_END: begin
          bank         <= ~bank;
          count        <= kept;
          expect_first <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      sstt_pkg::S_IDLE: begin
        if (det_valid) begin
          it.ident    <= source_id;
          it.x        <= pos_x;
          it.y        <= pos_y;
          it.z        <= pos_z;
          it.angle    <= azimuth;
          it.stamp    <= stamp;
          it_last     <= last_in_message;
          idx         <= '0;
          merge_found <= 1'b0;
          g2          <= 32'(distance_gate) * 32'(distance_gate);
        end
      end
      sstt_pkg::S_CHK: begin
        cur <= rd_data;
        if (id_match) begin
          res_kind <= sstt_pkg::EV_UPDATE;
          res_slot <= 4'(idx);
          res_id   <= it.ident;
          res_mask <= mask;
          ret      <= it_last ? sstt_pkg::S_AG_INIT : sstt_pkg::S_FLUSH;
        end else if (!try_merge) begin
          idx <= idx + 1'b1;
        end
      end
      sstt_pkg::S_DIST: begin
        if (dres.done) begin
          idx <= idx + 1'b1;
          if (dres.hit) begin
            merge_found <= 1'b1;
            merge_idx   <= idx[IW-1:0];
            merge_rec   <= cur;
          end
        end
      end
      sstt_pkg::S_DECIDE: begin
        res_mask <= 4'd0;
        ret      <= it_last ? sstt_pkg::S_AG_INIT : sstt_pkg::S_FLUSH;
        if (merge_found) begin
          res_kind <= sstt_pkg::EV_MERGE;
          res_slot <= 4'(merge_idx);
          res_id   <= merge_rec.ident;
        end else if (count < FULL_N) begin
          res_kind <= sstt_pkg::EV_ADD;
          res_slot <= 4'(count);
          res_id   <= it.ident;
        end else begin
          res_kind <= sstt_pkg::EV_DROP;
          res_slot <= 4'd0;
          res_id   <= it.ident;
        end
      end
      sstt_pkg::S_PUSH: begin
        // hold one event back so the final one can carry last_result
        if (push_ok) begin
          pend_kind <= res_kind;
          pend_slot <= res_slot;
          pend_id   <= res_id;
          pend_mask <= res_mask;
          if (pend_valid) begin
            out_kind <= pend_kind;
            out_slot <= pend_slot;
            out_id   <= pend_id;
            out_mask <= pend_mask;
            out_last <= 1'b0;
          end
        end
      end
      sstt_pkg::S_FLUSH: begin
        if (out_free) begin
          out_kind <= pend_kind;
          out_slot <= pend_slot;
          out_id   <= pend_id;
          out_mask <= pend_mask;
          out_last <= 1'b1;
        end
      end
      sstt_pkg::S_AG_INIT: begin
        rank       <= '0;
        kept       <= '0;
        nrem       <= 4'd0;
        have_prev  <= 1'b0;
        idx        <= '0;
        best_valid <= 1'b0;
      end
      sstt_pkg::S_AG_CHK: begin
        // pick the smallest (age, slot) above the previous pick
        if (after_prev && better) begin
          best       <= rd_data;
          best_age   <= ag_age;
          best_idx   <= idx[IW-1:0];
          best_valid <= 1'b1;
        end
        idx <= idx + 1'b1;
      end
      sstt_pkg::S_AG_RANK: begin
        have_prev <= 1'b1;
        prev_age  <= best_age;
        prev_idx  <= best_idx;
        if (!removing) begin
          kept <= kept + 1'b1;
        end else if (nrem < sstt_pkg::MAX_REMOVALS) begin
          res_kind <= sstt_pkg::EV_REMOVE;
          res_slot <= 4'(best_idx);
          res_id   <= best.ident;
          res_mask <= 4'd0;
          nrem     <= nrem + 4'd1;
          ret      <= sstt_pkg::S_AG_NEXT;
        end
      end
      sstt_pkg::S_AG_NEXT: begin
        rank       <= rank + 1'b1;
        idx        <= '0;
        best_valid <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

[hdl/sstt_dist.sv]
// ----------------------------------------------------------------------------
// sstt_dist
// Squared-distance gate: sums three squares with one shared multiplier.
// ----------------------------------------------------------------------------
module sstt_dist (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         dx,
  input  logic [15:0]         dy,
  input  logic [15:0]         dz,
  input  logic [31:0]         g2,
  output sstt_pkg::dist_res_t res
);

  logic [2:0]  step;
  logic [15:0] ax, ay, az;
  logic [15:0] op;
  logic [31:0] prod;
  logic [33:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (start) begin
      step <= 3'd1;
    end else if (step != 3'd0) begin
      step <= (step == 3'd5) ? 3'd0 : step + 3'd1;
    end
  end

  always_comb begin
    case (step)
      3'd1:    op = ax;
      3'd2:    op = ay;
      default: op = az;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax <= dx;
      ay <= dy;
      az <= dz;
    end
    if (step >= 3'd1 && step <= 3'd3) begin
      prod <= 32'(op) * 32'(op);
    end
    if (step == 3'd2) begin
      acc <= 34'(prod);
    end else if (step == 3'd3 || step == 3'd4) begin
      acc <= acc + 34'(prod);
    end
  end

  assign res.done = (step == 3'd5);
  assign res.hit  = (acc < 34'(g2));

endmodule

[hdl/sstt_check.sv]
// ----------------------------------------------------------------------------
// sstt_check
// Port-level checks on the sound source track table, bound to the top level.
// ----------------------------------------------------------------------------
`include "sound_source_track_table_macros.svh"

module sstt_check (
  input logic        clk,
  input logic        rst,
  input logic        det_valid,
  input logic        det_stall,
  input logic        evt_valid,
  input logic        evt_stall,
  input logic [2:0]  event_kind,
  input logic [3:0]  slot,
  input logic [15:0] entry_id,
  input logic [3:0]  changed_mask,
  input logic        last_result
);

  logic [27:0] evt_word;

  assign evt_word = {event_kind, slot, entry_id, changed_mask, last_result};

  `SSTT_ASSERT_NEXT(a_evt_hold, clk, rst, evt_valid && evt_stall, evt_valid && $stable(evt_word))
  `SSTT_ASSERT_NEXT(a_busy_after_det, clk, rst, det_valid && !det_stall, det_stall)
  `SSTT_ASSERT_NOW(a_kind_legal, clk, rst, evt_valid, event_kind <= sstt_pkg::EV_REMOVE)
  `SSTT_ASSERT_NOW(a_mask_update_only, clk, rst, evt_valid && event_kind != sstt_pkg::EV_UPDATE, changed_mask == 4'd0)

endmodule

bind sound_source_track_table sstt_check u_sstt_check (.*);
